>>> sv/bts_pkg.sv
// shared types and constants for the bandwidth-throttled stall timer
// no dependencies; used by the channel interfaces and the core
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // field widths
    localparam int BYTES_W    = 8;
    localparam int LIMIT_W    = 16;
    localparam int PEN_W      = 16;
    localparam int INTERVAL_W = 32;
    localparam int BASE_W     = 16;
    localparam int SRANGE_W   = 16;
    localparam int PRANGE_W   = 8;
    localparam int COUNT_W    = 32;
    localparam int RAND_W     = 31;
    localparam int STALL_W    = 18;
    localparam int RESULT_W   = 34;

    // bits moved per byte, as a shift
    localparam int BIT_SHIFT  = 3;

    // shared unit step counts
    localparam int MUL_STEPS  = 16;
    localparam int DIV_STEPS  = RAND_W;
    localparam int STEP_CNT_W = 5;

    // register reset values
    localparam logic [LIMIT_W-1:0]    RST_LIMIT    = 16'd8;
    localparam logic [PEN_W-1:0]      RST_PBASE    = 16'd2;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 32'd1000;
    localparam logic [BASE_W-1:0]     RST_BASE     = 16'd0;
    localparam logic [SRANGE_W-1:0]   RST_SRANGE   = 16'd0;
    localparam logic [PRANGE_W-1:0]   RST_PRANGE   = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BW_LIMIT      = 3'd0,
        CFG_PENALTY_BASE  = 3'd1,
        CFG_CHECK_INTERVAL= 3'd2,
        CFG_BASE_STALL    = 3'd3,
        CFG_STRESS_ENABLE = 3'd4,
        CFG_STRESS_RANGE  = 3'd5,
        CFG_PERTURB_RANGE = 3'd6,
        CFG_PERTURB_ALLOW = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BW_MUL,
        ST_BW_JUDGE,
        ST_STALL_BEGIN,
        ST_STRESS_DIV,
        ST_STRESS_APPLY,
        ST_PERT_BEGIN,
        ST_PERT_DIV,
        ST_PERT_APPLY,
        ST_SCALE_BEGIN,
        ST_SCALE_MUL,
        ST_SCALE_DONE,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> sv/bts_in_if.sv
// input channel: one memory access beat with valid/ready
// depends on bts_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bts_in_if #(
    parameter int CYCLE_BITS = 48
) ();
    logic                          valid;
    logic                          ready;
    logic [bts_pkg::BYTES_W-1:0]   access_bytes;
    logic                          may_stall;
    logic [CYCLE_BITS-1:0]         cycle_now;
    logic                          fast_mode;
    logic [bts_pkg::RAND_W-1:0]    rand_stress;
    logic                          rand_sign;
    logic [bts_pkg::RAND_W-1:0]    rand_perturb;

    modport source (
        output valid, access_bytes, may_stall, cycle_now, fast_mode,
               rand_stress, rand_sign, rand_perturb,
        input  ready
    );
    modport sink (
        input  valid, access_bytes, may_stall, cycle_now, fast_mode,
               rand_stress, rand_sign, rand_perturb,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/bts_out_if.sv
// output channel: one stall result beat with valid/ready
// depends on bts_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bts_out_if ();
    logic                          valid;
    logic                          ready;
    logic [bts_pkg::RESULT_W-1:0]  stall_cycles;
    logic                          throttled;
    logic [bts_pkg::COUNT_W-1:0]   penalty_events;

    modport source (
        output valid, stall_cycles, throttled, penalty_events,
        input  ready
    );
    modport sink (
        input  valid, stall_cycles, throttled, penalty_events,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/bandwidth_throttled_stall_timer_core.sv
// top level of the bandwidth-throttled stall timer
// depends on bts_pkg, bts_in_if and bts_out_if
`timescale 1ns / 1ps
`default_nettype none

// Takes one memory access beat at a time and returns one result beat with the
// stall to apply, whether the bandwidth penalty hit this access, and the running
// penalty count. Bytes are summed over a window; once the window is older than
// check_interval, elapsed*limit is compared with bytes*8 and either the penalty
// applies (and rises) or a new window opens. Multiplies and remainders run on
// one shared shift-add / shift-subtract unit: a 16-step multiply for the
// bandwidth check, a 31-step restoring remainder for the stress word, another
// for the perturb word, and a 16-step multiply to scale a throttled stall; the
// input is ready only while the sequencer is idle. The result sits in an output
// register, so the next access is taken while a result still waits.
// Configuration is written through a plain write port; the user must ensure it
// is only changed while the block is idle, as the block does not enforce this.

module bandwidth_throttled_stall_timer_core #(
    parameter int CYCLE_BITS      = 48,
    parameter int BYTE_COUNT_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bts_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    bts_in_if.sink                           i_in,
    bts_out_if.source                        o_out
);

    // shared unit accumulator must hold elapsed * limit
    localparam int ACC_W = CYCLE_BITS + bts_pkg::LIMIT_W;
    localparam int WB8_W = BYTE_COUNT_BITS + bts_pkg::BIT_SHIFT;
    localparam int CMP_W = (ACC_W > WB8_W) ? ACC_W : WB8_W;

    // configuration registers
    logic [bts_pkg::LIMIT_W-1:0]    r_cfg_limit;
    logic [bts_pkg::PEN_W-1:0]      r_cfg_pbase;
    logic [bts_pkg::INTERVAL_W-1:0] r_cfg_interval;
    logic [bts_pkg::BASE_W-1:0]     r_cfg_base;
    logic                           r_cfg_senable;
    logic [bts_pkg::SRANGE_W-1:0]   r_cfg_srange;
    logic [bts_pkg::PRANGE_W-1:0]   r_cfg_prange;
    logic                           r_cfg_pallow;

    // throttle bookkeeping
    logic [CYCLE_BITS-1:0]          r_wstart;
    logic [BYTE_COUNT_BITS-1:0]     r_wb;
    logic [bts_pkg::PEN_W-1:0]      r_pen;
    logic [bts_pkg::COUNT_W-1:0]    r_pen_count;

    // sequencer
    bts_pkg::t_state                r_state;
    bts_pkg::t_state                n_state;

    // captured access
    logic [CYCLE_BITS-1:0]          r_now;
    logic                           r_may_stall;
    logic                           r_sign;
    logic [bts_pkg::RAND_W-1:0]     r_rand_stress;
    logic [bts_pkg::RAND_W-1:0]     r_rand_pert;

    // per-access working values
    logic                           r_thr;
    logic [bts_pkg::PEN_W-1:0]      r_factor;
    logic [bts_pkg::STALL_W-1:0]    r_stall;
    logic [bts_pkg::RESULT_W-1:0]   r_result;

    // shared unit
    logic [ACC_W-1:0]               r_acc;
    logic [CYCLE_BITS-1:0]          r_opa;
    logic [bts_pkg::RAND_W-1:0]     r_shf;
    logic [bts_pkg::STEP_CNT_W-1:0] r_cnt;

    // output register
    logic                           r_o_valid;
    logic [bts_pkg::RESULT_W-1:0]   r_o_stall;
    logic                           r_o_thr;
    logic [bts_pkg::COUNT_W-1:0]    r_o_events;

    logic                           in_fire;
    logic                           active;
    logic [BYTE_COUNT_BITS:0]       wb_sum;
    logic [BYTE_COUNT_BITS-1:0]     wb_sat;
    logic [CYCLE_BITS-1:0]          elapsed;
    logic                           window_due;
    logic [bts_pkg::PEN_W-1:0]      pen_eff;
    logic                           div_mode;
    logic                           iterating;
    logic [ACC_W-1:0]               u_t;
    logic [ACC_W-1:0]               u_y;
    logic [ACC_W:0]                 u_sum;
    logic [ACC_W-1:0]               u_next;
    logic                           over_limit;
    logic                           stress_on;
    logic                           pert_on;
    logic [bts_pkg::STALL_W-1:0]    s_val;
    logic [bts_pkg::STALL_W-1:0]    stress_stall;
    logic                           out_free;

    assign i_in.ready   = (r_state == bts_pkg::ST_IDLE);
    assign in_fire      = i_in.valid && i_in.ready;
    assign out_free     = !r_o_valid || o_out.ready;

    assign o_out.valid          = r_o_valid;
    assign o_out.stall_cycles   = r_o_stall;
    assign o_out.throttled      = r_o_thr;
    assign o_out.penalty_events = r_o_events;

    // window update at acceptance
    assign active  = (r_cfg_limit != '0) && !i_in.fast_mode;
    assign wb_sum  = {1'b0, r_wb} + (BYTE_COUNT_BITS + 1)'(i_in.access_bytes);
    assign wb_sat  = wb_sum[BYTE_COUNT_BITS] ? '1 : wb_sum[BYTE_COUNT_BITS-1:0];
    assign elapsed = i_in.cycle_now - r_wstart;
    assign window_due = active && (elapsed > CYCLE_BITS'(r_cfg_interval));
    assign pen_eff = (r_pen == '0) ? r_cfg_pbase : r_pen;

    // shared shift-add / shift-subtract step, msb first
    assign div_mode  = (r_state == bts_pkg::ST_STRESS_DIV) ||
                       (r_state == bts_pkg::ST_PERT_DIV);
    assign iterating = div_mode || (r_state == bts_pkg::ST_BW_MUL) ||
                       (r_state == bts_pkg::ST_SCALE_MUL);
    assign u_t   = {r_acc[ACC_W-2:0], div_mode & r_shf[bts_pkg::RAND_W-1]};
    assign u_y   = (div_mode || r_shf[bts_pkg::RAND_W-1]) ? ACC_W'(r_opa) : '0;
    assign u_sum = div_mode ? ({1'b0, u_t} - {1'b0, u_y}) : ({1'b0, u_t} + {1'b0, u_y});
    // on a borrow the trial subtract is dropped
    assign u_next = (div_mode && u_sum[ACC_W]) ? u_t : u_sum[ACC_W-1:0];

    // traffic reached the allowance: elapsed*limit <= bytes*8
    assign over_limit = CMP_W'(r_acc) <= CMP_W'({r_wb, 3'b000});

    assign stress_on = r_cfg_pallow && r_cfg_senable && (r_cfg_srange != '0);
    assign pert_on   = r_cfg_pallow && (r_cfg_prange != '0);

    // stress remainder is below stress_range+1, so it fits the 17-bit slice taken here
    assign s_val = bts_pkg::STALL_W'(r_acc[bts_pkg::SRANGE_W:0]);
    always_comb begin
        if (r_cfg_srange > r_cfg_base) begin
            stress_stall = s_val;
        end else if (r_sign) begin
            stress_stall = r_stall - s_val;
        end else begin
            stress_stall = r_stall + s_val;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bts_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = window_due ? bts_pkg::ST_BW_MUL : bts_pkg::ST_STALL_BEGIN;
                end
            end
            bts_pkg::ST_BW_MUL: begin
                if (r_cnt == '0) n_state = bts_pkg::ST_BW_JUDGE;
            end
            bts_pkg::ST_BW_JUDGE: begin
                n_state = bts_pkg::ST_STALL_BEGIN;
            end
            bts_pkg::ST_STALL_BEGIN: begin
                if (!r_may_stall) begin
                    n_state = bts_pkg::ST_OUT;
                end else if (stress_on) begin
                    n_state = bts_pkg::ST_STRESS_DIV;
                end else begin
                    n_state = bts_pkg::ST_PERT_BEGIN;
                end
            end
            bts_pkg::ST_STRESS_DIV: begin
                if (r_cnt == '0) n_state = bts_pkg::ST_STRESS_APPLY;
            end
            bts_pkg::ST_STRESS_APPLY: begin
                n_state = bts_pkg::ST_PERT_BEGIN;
            end
            bts_pkg::ST_PERT_BEGIN: begin
                n_state = pert_on ? bts_pkg::ST_PERT_DIV : bts_pkg::ST_SCALE_BEGIN;
            end
            bts_pkg::ST_PERT_DIV: begin
                if (r_cnt == '0) n_state = bts_pkg::ST_PERT_APPLY;
            end
            bts_pkg::ST_PERT_APPLY: begin
                n_state = bts_pkg::ST_SCALE_BEGIN;
            end
            bts_pkg::ST_SCALE_BEGIN: begin
                n_state = r_thr ? bts_pkg::ST_SCALE_MUL : bts_pkg::ST_OUT;
            end
            bts_pkg::ST_SCALE_MUL: begin
                if (r_cnt == '0) n_state = bts_pkg::ST_SCALE_DONE;
            end
            bts_pkg::ST_SCALE_DONE: begin
                n_state = bts_pkg::ST_OUT;
            end
            bts_pkg::ST_OUT: begin
                if (out_free) n_state = bts_pkg::ST_IDLE;
            end
            default: begin
                n_state = bts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit    <= bts_pkg::RST_LIMIT;
            r_cfg_pbase    <= bts_pkg::RST_PBASE;
            r_cfg_interval <= bts_pkg::RST_INTERVAL;
            r_cfg_base     <= bts_pkg::RST_BASE;
            r_cfg_senable  <= 1'b0;
            r_cfg_srange   <= bts_pkg::RST_SRANGE;
            r_cfg_prange   <= bts_pkg::RST_PRANGE;
            r_cfg_pallow   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bts_pkg::CFG_BW_LIMIT:       r_cfg_limit    <= i_cfg_wdata[bts_pkg::LIMIT_W-1:0];
                bts_pkg::CFG_PENALTY_BASE:   r_cfg_pbase    <= i_cfg_wdata[bts_pkg::PEN_W-1:0];
                bts_pkg::CFG_CHECK_INTERVAL: r_cfg_interval <= i_cfg_wdata;
                bts_pkg::CFG_BASE_STALL:     r_cfg_base     <= i_cfg_wdata[bts_pkg::BASE_W-1:0];
                bts_pkg::CFG_STRESS_ENABLE:  r_cfg_senable  <= i_cfg_wdata[0];
                bts_pkg::CFG_STRESS_RANGE:   r_cfg_srange   <= i_cfg_wdata[bts_pkg::SRANGE_W-1:0];
                bts_pkg::CFG_PERTURB_RANGE:  r_cfg_prange   <= i_cfg_wdata[bts_pkg::PRANGE_W-1:0];
                bts_pkg::CFG_PERTURB_ALLOW:  r_cfg_pallow   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // throttle bookkeeping, penalty flag and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart    <= '0;
            r_wb        <= '0;
            r_pen       <= '0;
            r_pen_count <= '0;
            r_thr       <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (r_state == bts_pkg::ST_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                bts_pkg::ST_IDLE: begin
                    if (in_fire) begin
                        r_pen <= pen_eff;
                        r_thr <= 1'b0;
                        if (active) r_wb <= wb_sat;
                    end
                end
                bts_pkg::ST_BW_JUDGE: begin
                    if (over_limit) begin
                        r_thr <= 1'b1;
                        if (r_pen_count != '1) r_pen_count <= r_pen_count + 1'b1;
                        if (r_pen != '1) r_pen <= r_pen + 1'b1;
                    end else begin
                        r_wstart <= r_now;
                        r_wb     <= '0;
                        r_pen    <= r_cfg_pbase;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath and shared unit
    always_ff @(posedge i_clk) begin
        if (iterating) begin
            r_acc <= u_next;
            r_shf <= {r_shf[bts_pkg::RAND_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
        case (r_state)
            bts_pkg::ST_IDLE: begin
                if (in_fire) begin
                    r_now         <= i_in.cycle_now;
                    r_may_stall   <= i_in.may_stall;
                    r_sign        <= i_in.rand_sign;
                    r_rand_stress <= i_in.rand_stress;
                    r_rand_pert   <= i_in.rand_perturb;
                    // multiplier loads msb first
                    r_acc <= '0;
                    r_opa <= elapsed;
                    r_shf <= {r_cfg_limit, (bts_pkg::RAND_W - bts_pkg::LIMIT_W)'(0)};
                    r_cnt <= bts_pkg::STEP_CNT_W'(bts_pkg::MUL_STEPS - 1);
                end
            end
            bts_pkg::ST_BW_JUDGE: begin
                r_factor <= r_pen;
            end
            bts_pkg::ST_STALL_BEGIN: begin
                r_stall  <= bts_pkg::STALL_W'(r_cfg_base);
                r_result <= '0;
                r_acc    <= '0;
                r_opa    <= CYCLE_BITS'(r_cfg_srange) + 1'b1;
                r_shf    <= r_rand_stress;
                r_cnt    <= bts_pkg::STEP_CNT_W'(bts_pkg::DIV_STEPS - 1);
            end
            bts_pkg::ST_STRESS_APPLY: begin
                r_stall <= stress_stall;
            end
            bts_pkg::ST_PERT_BEGIN: begin
                r_acc <= '0;
                r_opa <= CYCLE_BITS'(r_cfg_prange) + 1'b1;
                r_shf <= r_rand_pert;
                r_cnt <= bts_pkg::STEP_CNT_W'(bts_pkg::DIV_STEPS - 1);
            end
            bts_pkg::ST_PERT_APPLY: begin
                r_stall <= r_stall + bts_pkg::STALL_W'(r_acc[bts_pkg::PRANGE_W:0]);
            end
            bts_pkg::ST_SCALE_BEGIN: begin
                r_result <= bts_pkg::RESULT_W'(r_stall);
                r_acc    <= '0;
                r_opa    <= CYCLE_BITS'(r_stall);
                r_shf    <= {r_factor, (bts_pkg::RAND_W - bts_pkg::PEN_W)'(0)};
                r_cnt    <= bts_pkg::STEP_CNT_W'(bts_pkg::MUL_STEPS - 1);
            end
            bts_pkg::ST_SCALE_DONE: begin
                r_result <= r_acc[bts_pkg::RESULT_W-1:0];
            end
            bts_pkg::ST_OUT: begin
                if (out_free) begin
                    r_o_stall  <= r_result;
                    r_o_thr    <= r_thr;
                    r_o_events <= r_pen_count;
                end
            end
            default: begin
            end
        endcase
    end

    // a throttled result always carries a nonzero penalty count
    a_thr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_thr) |-> (r_o_events != '0))
        else $error("throttled beat with zero penalty count");

    // an accepted beat always starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != bts_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accept");

    // penalty count never falls outside reset
    a_count_mono: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_pen_count >= $past(r_pen_count)))
        else $error("penalty count decreased");

    // penalty count only moves in the judge step
    a_count_judge: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && (r_pen_count != $past(r_pen_count)))
        |-> ($past(r_state) == bts_pkg::ST_BW_JUDGE))
        else $error("penalty count changed outside judge");

    // an unstallable access leaves the stall path with zero
    a_nostall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bts_pkg::ST_STALL_BEGIN && !r_may_stall) |=> (r_result == '0))
        else $error("unstallable access has nonzero stall");

endmodule

`default_nettype wire
